[src/sobel_nonmax_suppression_defines.svh]
// Assertion helpers shared by the edge detector RTL.
`ifndef SOBEL_NONMAX_SUPPRESSION_DEFINES_SVH
`define SOBEL_NONMAX_SUPPRESSION_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SNMS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("snms: invariant violated");

// Antecedent implies consequent in the same cycle.
`define SNMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snms: implication violated");

// Antecedent implies consequent in the next cycle.
`define SNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snms: next-cycle check violated");

`endif

[src/snms_pkg.sv]
// ----------------------------------------------------------------------------
// snms_pkg
// Shared widths, codes, types and helpers of the Sobel / non-max block.
// ----------------------------------------------------------------------------
package snms_pkg;

    localparam int PIX_W       = 8;
    localparam int MAG_W       = 8;
    localparam int DIR_W       = 2;
    localparam int GRAD_W      = 11;           // signed Sobel sum, |g| <= 1020
    localparam int ABS_W       = GRAD_W - 1;
    localparam int SQ_W        = 2 * ABS_W + 1; // gx^2 + gy^2
    localparam int ROW_W       = 12;
    localparam int HGT_W       = 13;           // holds the frame height itself
    localparam int COL_OUT_W   = 11;
    localparam int WREG_W      = 12;
    localparam int HREG_W      = 13;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int HEIGHT_MAX  = 4096;
    localparam int WIDTH_RESET = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int TAN_LOW     = 106;          // tan(22.5) * 256
    localparam int TAN_HIGH    = 618;          // tan(67.5) * 256

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Direction bins
    localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

    // Pixel line entry: live flag (not a flush) and value
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
    } t_pix_cell;

    // Magnitude line entry
    typedef struct packed {
        logic             valid;
        logic [DIR_W-1:0] dir;
        logic [MAG_W-1:0] mag;
    } t_mag_cell;

    // Gradient record handed from the front to the back
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [ROW_W-1:0]         a_row;
        logic                     a_valid;
        logic                     b_epoch;
    } t_grad;

    // Row one raster line plus one pixel earlier, wrapping into the prior frame
    function automatic logic [ROW_W-1:0] back_row(input logic [ROW_W-1:0] row,
                                                  input logic [HGT_W-1:0] h,
                                                  input logic two);
        logic [HGT_W-1:0] r;
        logic [HGT_W-1:0] d;
        r = HGT_W'(row);
        d = two ? HGT_W'(2) : HGT_W'(1);
        if (r >= d) begin
            return ROW_W'(r - d);
        end
        return ROW_W'(r + h - d);
    endfunction

endpackage

[src/snms_pix_if.sv]
// ----------------------------------------------------------------------------
// snms_pix_if
// Pixel input channel: valid/ready with pixel value and flush flag.
// ----------------------------------------------------------------------------
interface snms_pix_if import snms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             flush;

    modport source (output valid, output pixel, output flush, input ready);
    modport sink   (input valid, input pixel, input flush, output ready);
endinterface

[src/snms_edge_if.sv]
// ----------------------------------------------------------------------------
// snms_edge_if
// Edge result channel: valid/ready with suppressed magnitude and position.
// ----------------------------------------------------------------------------
interface snms_edge_if import snms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MAG_W-1:0]     edge_value;
    logic [DIR_W-1:0]     direction_bin;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_W-1:0]     row;
    logic                 frame_last;

    modport source (output valid, output edge_value, output direction_bin,
                    output column, output row, output frame_last, input ready);
    modport sink   (input valid, input edge_value, input direction_bin,
                    input column, input row, input frame_last, output ready);
endinterface

[src/snms_queue.sv]
// ----------------------------------------------------------------------------
// snms_queue
// Small register FIFO between the gradient front and the suppression back.
// ----------------------------------------------------------------------------
`include "sobel_nonmax_suppression_defines.svh"

module snms_queue import snms_pkg::*; #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_buf[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SNMS_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SNMS_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `SNMS_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `SNMS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

[src/snms_front.sv]
// ----------------------------------------------------------------------------
// snms_front
// Accepts pixel beats, keeps the raster position and pixel line store, and
// forms the Sobel gradients of the pixel one row and one column back.
// ----------------------------------------------------------------------------
module snms_front import snms_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11,
    parameter int WW        = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [WW-1:0]     i_width,
    input  logic [HGT_W-1:0]  i_height,
    snms_pix_if.sink          i_pix,
    output logic              o_push,
    output t_grad             o_grad,
    output logic [COL_W-1:0]  o_col,
    input  logic              i_full
);

    localparam int FILL_W = $clog2(2 * MAX_WIDTH + 3);

    typedef enum logic {S_IDLE, S_CALC} t_state;

    typedef struct packed {
        t_pix_cell prev1;
        t_pix_cell prev2;
    } t_pix_pair;

    t_pix_pair        r_line_mem [MAX_WIDTH];
    t_pix_pair        r_rd;
    t_pix_cell        r_cell;
    t_pix_cell        r_win [3][3];
    t_pix_cell        n_win [3][3];
    t_state           r_state;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [FILL_W-1:0] r_fill;

    logic             accept;
    logic             commit;
    logic [COL_W-1:0] a_col;
    logic [ROW_W-1:0] a_row;
    logic             m_top, m_bot, m_left, m_right;
    logic [PIX_W-1:0] v [3][3];
    logic [GRAD_W-1:0] s_left, s_right, s_top, s_bot;
    logic [FILL_W-1:0] th_a, th_b;
    logic             col_last;

    assign i_pix.ready = (r_state == S_IDLE);
    assign accept      = i_pix.valid && (r_state == S_IDLE);
    assign commit      = (r_state == S_CALC) && !i_full;

    assign th_a     = FILL_W'(i_width) + FILL_W'(1);
    assign th_b     = (FILL_W'(i_width) << 1) + FILL_W'(2);
    assign col_last = (WW'(r_col) == i_width - WW'(1));

    // Position being filtered: W+1 beats behind the incoming one
    assign a_col   = (r_col != '0) ? r_col - 1'b1 : COL_W'(i_width - WW'(1));
    assign a_row   = back_row(r_row, i_height, r_col == '0);
    assign m_top   = (a_row == '0);
    assign m_bot   = (HGT_W'(a_row) == i_height - HGT_W'(1));
    assign m_left  = (a_col == '0);
    assign m_right = (WW'(a_col) == i_width - WW'(1));

    // Window shift and zero padding outside the frame
    always_comb begin
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = r_rd.prev2;
        n_win[2][1] = r_rd.prev1;
        n_win[2][2] = r_cell;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (((c == 0) && m_left) || ((c == 2) && m_right) ||
                    ((r == 0) && m_top)  || ((r == 2) && m_bot)) begin
                    v[c][r] = '0;
                end else begin
                    v[c][r] = n_win[c][r].pix;
                end
            end
        end
    end

    // Sobel column and row sums
    assign s_left  = GRAD_W'(v[0][0]) + (GRAD_W'(v[0][1]) << 1) + GRAD_W'(v[0][2]);
    assign s_right = GRAD_W'(v[2][0]) + (GRAD_W'(v[2][1]) << 1) + GRAD_W'(v[2][2]);
    assign s_top   = GRAD_W'(v[0][0]) + (GRAD_W'(v[1][0]) << 1) + GRAD_W'(v[2][0]);
    assign s_bot   = GRAD_W'(v[0][2]) + (GRAD_W'(v[1][2]) << 1) + GRAD_W'(v[2][2]);

    assign o_push        = commit;
    assign o_col         = a_col;
    assign o_grad.gx     = $signed(s_right - s_left);
    assign o_grad.gy     = $signed(s_bot - s_top);
    assign o_grad.a_row  = a_row;
    assign o_grad.a_valid = n_win[1][1].valid && (r_fill >= th_a);
    assign o_grad.b_epoch = (r_fill >= th_b);

    // Pixel line store: read on accept, write back on commit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd   <= r_line_mem[r_col];
            r_cell <= '{valid: !i_pix.flush, pix: i_pix.flush ? '0 : i_pix.pixel};
        end
        if (commit) begin
            r_line_mem[r_col] <= '{prev1: r_cell, prev2: r_rd.prev1};
            r_win             <= n_win;
        end
    end

    // Control: state, raster position, fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
        end else if (i_restart) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                        if (r_fill < th_b) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (col_last) begin
                            r_col <= '0;
                            if (HGT_W'(r_row) == i_height - HGT_W'(1)) begin
                                r_row <= '0;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/snms_back.sv]
// ----------------------------------------------------------------------------
// snms_back
// Magnitude (iterative square root), direction bin, magnitude line store
// and suppression along the bin; drives the result register.
// ----------------------------------------------------------------------------
module snms_back import snms_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11,
    parameter int WW        = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WW-1:0]    i_width,
    input  logic [HGT_W-1:0] i_height,
    input  logic             i_empty,
    output logic             o_pop,
    input  t_grad            i_grad,
    input  logic [COL_W-1:0] i_col,
    snms_edge_if.source      o_edge
);

    localparam int K_W = $clog2(MAG_W);
    localparam logic [SQ_W-1:0] SQRT_SAT = SQ_W'(1) << (2 * MAG_W);

    typedef enum logic [2:0] {S_IDLE, S_SQUARE, S_SUM, S_ROOT, S_EMIT} t_state;

    typedef struct packed {
        t_mag_cell prev1;
        t_mag_cell prev2;
    } t_mag_pair;

    t_mag_pair          r_line_mem [MAX_WIDTH];
    t_mag_pair          r_rd;
    t_mag_cell          r_win [3][3];
    t_mag_cell          n_win [3][3];
    t_state             r_state;
    t_grad              r_grad;
    logic [COL_W-1:0]   r_acol;
    logic [2*ABS_W-1:0] r_ax2;
    logic [ABS_W-1:0]   r_ay;
    logic [DIR_W-1:0]   r_dir;
    logic [SQ_W-1:0]    r_sq;
    logic [MAG_W-1:0]   r_root;
    logic [K_W-1:0]     r_k;

    logic                 r_out_valid;
    logic [MAG_W-1:0]     r_out_edge;
    logic [DIR_W-1:0]     r_out_dir;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [ROW_W-1:0]     r_out_row;
    logic                 r_out_last;

    logic [ABS_W-1:0]   ax, ay;
    logic [2*ABS_W-1:0] ay_lo, ax_lo, ax_hi;
    logic [MAG_W-1:0]   trial;
    logic [2*MAG_W-1:0] trial_sq;
    logic               commit;
    logic [COL_W-1:0]   b_col;
    logic [ROW_W-1:0]   b_row;
    logic               m_top, m_bot, m_left, m_right;
    logic [MAG_W-1:0]   mv [3][3];
    logic [MAG_W-1:0]   n1, n2;
    t_mag_cell          ctr;
    logic [MAG_W-1:0]   edge_val;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign commit = (r_state == S_EMIT) && (!r_out_valid || o_edge.ready);

    // Absolute gradients and tangent compares
    assign ax    = ABS_W'(r_grad.gx[GRAD_W-1] ? -r_grad.gx : r_grad.gx);
    assign ay    = ABS_W'(r_grad.gy[GRAD_W-1] ? -r_grad.gy : r_grad.gy);
    assign ay_lo = (2*ABS_W)'(ay) << 8;
    assign ax_lo = (2*ABS_W)'(ax) * (2*ABS_W)'(TAN_LOW);
    assign ax_hi = (2*ABS_W)'(ax) * (2*ABS_W)'(TAN_HIGH);

    // Square root trial bit
    assign trial    = r_root | (MAG_W'(1) << r_k);
    assign trial_sq = trial * trial;

    // Pixel being suppressed: W+1 beats behind the filtered one
    assign b_col   = (r_acol != '0) ? r_acol - 1'b1 : COL_W'(i_width - WW'(1));
    assign b_row   = back_row(r_grad.a_row, i_height, r_acol == '0);
    assign m_top   = (b_row == '0);
    assign m_bot   = (HGT_W'(b_row) == i_height - HGT_W'(1));
    assign m_left  = (b_col == '0);
    assign m_right = (WW'(b_col) == i_width - WW'(1));

    // Window shift, border masking, neighbour pick along the bin
    always_comb begin
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = r_rd.prev2;
        n_win[2][1] = r_rd.prev1;
        n_win[2][2] = '{valid: r_grad.a_valid, dir: r_dir, mag: r_root};
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (((c == 0) && m_left) || ((c == 2) && m_right) ||
                    ((r == 0) && m_top)  || ((r == 2) && m_bot)) begin
                    mv[c][r] = '0;
                end else begin
                    mv[c][r] = n_win[c][r].mag;
                end
            end
        end
        ctr = n_win[1][1];
        case (ctr.dir)
            DIR_0: begin
                n1 = mv[0][1];
                n2 = mv[2][1];
            end
            DIR_45: begin
                n1 = mv[0][0];
                n2 = mv[2][2];
            end
            DIR_90: begin
                n1 = mv[1][0];
                n2 = mv[1][2];
            end
            DIR_135: begin
                n1 = mv[2][0];
                n2 = mv[0][2];
            end
            default: begin
                n1 = '0;
                n2 = '0;
            end
        endcase
        edge_val = ((ctr.mag >= n1) && (ctr.mag >= n2)) ? ctr.mag : '0;
    end

    assign o_edge.valid         = r_out_valid;
    assign o_edge.edge_value    = r_out_edge;
    assign o_edge.direction_bin = r_out_dir;
    assign o_edge.column        = r_out_col;
    assign o_edge.row           = r_out_row;
    assign o_edge.frame_last    = r_out_last;

    // Datapath registers and magnitude line store
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grad <= i_grad;
            r_acol <= i_col;
            r_rd   <= r_line_mem[i_col];
        end
        if (r_state == S_SQUARE) begin
            r_ax2 <= (2*ABS_W)'(ax) * (2*ABS_W)'(ax);
            r_ay  <= ay;
            if ((ax == '0) && (ay == '0)) begin
                r_dir <= DIR_0;
            end else if (ay_lo < ax_lo) begin
                r_dir <= DIR_0;
            end else if (ay_lo >= ax_hi) begin
                r_dir <= DIR_90;
            end else if (r_grad.gx[GRAD_W-1] == r_grad.gy[GRAD_W-1]) begin
                r_dir <= DIR_45;
            end else begin
                r_dir <= DIR_135;
            end
        end
        if (r_state == S_SUM) begin
            r_sq   <= SQ_W'(r_ax2) + SQ_W'((2*ABS_W)'(r_ay) * (2*ABS_W)'(r_ay));
            r_root <= '0;
            r_k    <= K_W'(MAG_W - 1);
        end
        if (r_state == S_ROOT) begin
            if (r_sq >= SQRT_SAT) begin
                r_root <= '1;
            end else begin
                if (SQ_W'(trial_sq) <= r_sq) begin
                    r_root <= trial;
                end
                r_k <= r_k - 1'b1;
            end
        end
        if (commit) begin
            r_line_mem[r_acol] <= '{prev1: n_win[2][2], prev2: r_rd.prev1};
            r_win              <= n_win;
            r_out_edge         <= edge_val;
            r_out_dir          <= ctr.dir;
            r_out_col          <= COL_OUT_W'(b_col);
            r_out_row          <= b_row;
            r_out_last         <= m_bot && m_right;
        end
    end

    // Control: sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= ctr.valid && r_grad.b_epoch;
            end else if (o_edge.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if ((r_sq >= SQRT_SAT) || (r_k == '0)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/sobel_nonmax_suppression.sv]
// ----------------------------------------------------------------------------
// sobel_nonmax_suppression
// Sobel gradient magnitude and direction with non-maximum suppression over
// a raster pixel stream; configuration registers set the frame size.
//
//   channel   dir   beat contents
//   i_pix     in    pixel, flush
//   o_edge    out   edge_value, direction_bin, column, row, frame_last
//   i_cfg_*   in    register index and write data, one write per enable
//
// The front takes no new beat until the last one is in the queue, and it
// holds while the queue is full. The back takes no new beat until the last
// is emitted; its bit-serial root, cut short on saturation, sets the rate.
// A result trails its input by 2*W+2 beats; flush beats drain the frame.
// Reset and any register write restart at row 0, column 0; no clearing pass.
// A stalled result register holds the back, the full queue holds the front.
// ----------------------------------------------------------------------------
module sobel_nonmax_suppression import snms_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    snms_pix_if.sink             i_pix,
    snms_edge_if.source          o_edge
);

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int QDEPTH = 4;
    localparam int QW     = $bits(t_grad) + COL_W;

    logic [WREG_W-1:0] r_cfg_width;
    logic [HREG_W-1:0] r_cfg_height;
    logic [WW-1:0]     w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              restart;

    logic              q_push, q_pop, q_full, q_empty;
    t_grad             f_grad, b_grad;
    logic [COL_W-1:0]  f_col, b_col;
    logic [QW-1:0]     q_out;

    // Configuration registers
    assign restart = i_cfg_we &&
                     ((i_cfg_index == CFG_IMAGE_WIDTH) || (i_cfg_index == CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WREG_W'(WIDTH_RESET);
            r_cfg_height <= HREG_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WREG_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp to the supported frame size
    always_comb begin
        if (int'(r_cfg_width) < 3) begin
            w_eff = WW'(3);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (int'(r_cfg_height) < 3) begin
            h_eff = HGT_W'(3);
        end else if (int'(r_cfg_height) > HEIGHT_MAX) begin
            h_eff = HGT_W'(HEIGHT_MAX);
        end else begin
            h_eff = HGT_W'(r_cfg_height);
        end
    end

    snms_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .WW        (WW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .i_pix     (i_pix),
        .o_push    (q_push),
        .o_grad    (f_grad),
        .o_col     (f_col),
        .i_full    (q_full)
    );

    snms_queue #(
        .DEPTH  (QDEPTH),
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_grad, f_col}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign b_grad = q_out[QW-1:COL_W];
    assign b_col  = q_out[COL_W-1:0];

    snms_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .WW        (WW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (w_eff),
        .i_height (h_eff),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_grad   (b_grad),
        .i_col    (b_col),
        .o_edge   (o_edge)
    );

endmodule
